/* hw/rtl/hsvg_pkg.sv */
// Shared types, widths and constants of the HSV to RGB gamma pipeline.
package hsvg_pkg;

  // Field widths
  localparam int unsigned OP_W   = 1;
  localparam int unsigned HUE_W  = 9;
  localparam int unsigned LVL_W  = 8;
  localparam int unsigned F_W    = 6;   // hue offset inside a sector, 0..59
  localparam int unsigned FC_W   = 7;   // 60 - f, 1..60
  localparam int unsigned PROD_W = 14;  // S*f and S*(60-f), up to 15300
  localparam int unsigned PN_W   = 16;  // V*(255-S)
  localparam int unsigned QT_W   = 22;  // V*(15300-x)

  // Arithmetic constants
  localparam logic [HUE_W-1:0] HUE_MAX    = 9'd359;
  localparam int unsigned      SECTOR_DEG = 60;
  localparam int unsigned      FULL       = 255;
  localparam int unsigned      QT_DEN     = FULL * SECTOR_DEG;

  // Reciprocals: floor(x/255) = (x*P_RECIP) >> P_SHIFT for x < 2^16,
  // floor(x/15300) = (x*QT_RECIP) >> QT_SHIFT for x < 2^22.
  localparam int unsigned         P_RECIP_W  = 16;
  localparam logic [P_RECIP_W-1:0] P_RECIP   = 16'd32897;
  localparam int unsigned         P_SHIFT    = 23;
  localparam int unsigned         QT_RECIP_W = 23;
  localparam logic [QT_RECIP_W-1:0] QT_RECIP = 23'd4491470;
  localparam int unsigned         QT_SHIFT   = 36;

  // Gamma table
  localparam int unsigned GAMMA_DEPTH = 256;

  typedef enum logic [OP_W-1:0] {
    OP_CONVERT = 1'b0,
    OP_WRITE   = 1'b1
  } hsvg_op_e;

  // 60 degree hue sectors
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } hsvg_sector_e;

  // Stage 1: sector split
  typedef struct packed {
    hsvg_op_e          op;
    hsvg_sector_e      sector;
    logic [F_W-1:0]    f;
    logic [LVL_W-1:0]  s;
    logic [LVL_W-1:0]  v;
    logic              s_zero;
    logic [LVL_W-1:0]  idx;
    logic [LVL_W-1:0]  val;
  } hsvg_s1_t;

  // Stage 2: first products
  typedef struct packed {
    hsvg_op_e           op;
    hsvg_sector_e       sector;
    logic [LVL_W-1:0]   v;
    logic               s_zero;
    logic [PROD_W-1:0]  sf;
    logic [PROD_W-1:0]  sfc;
    logic [PN_W-1:0]    pn;
    logic [LVL_W-1:0]   idx;
    logic [LVL_W-1:0]   val;
  } hsvg_s2_t;

  typedef struct packed {
    logic     valid;
    hsvg_s2_t data;
  } hsvg_s2_link_t;

  // Stage 3: numerators
  typedef struct packed {
    hsvg_op_e          op;
    hsvg_sector_e      sector;
    logic [LVL_W-1:0]  v;
    logic              s_zero;
    logic [QT_W-1:0]   qn;
    logic [QT_W-1:0]   tn;
    logic [PN_W-1:0]   pn;
    logic [LVL_W-1:0]  idx;
    logic [LVL_W-1:0]  val;
  } hsvg_s3_t;

  // Stage 4: levels p, q, t
  typedef struct packed {
    hsvg_op_e          op;
    hsvg_sector_e      sector;
    logic [LVL_W-1:0]  v;
    logic              s_zero;
    logic [LVL_W-1:0]  p;
    logic [LVL_W-1:0]  q;
    logic [LVL_W-1:0]  t;
    logic [LVL_W-1:0]  idx;
    logic [LVL_W-1:0]  val;
  } hsvg_s4_t;

  typedef struct packed {
    logic     valid;
    hsvg_s4_t data;
  } hsvg_s4_link_t;

  // Stage 5: channel levels before gamma
  typedef struct packed {
    hsvg_op_e          op;
    logic [LVL_W-1:0]  v;
    logic              s_zero;
    logic [LVL_W-1:0]  r;
    logic [LVL_W-1:0]  g;
    logic [LVL_W-1:0]  b;
    logic [LVL_W-1:0]  idx;
    logic [LVL_W-1:0]  val;
  } hsvg_s5_t;

  // Stage 6: side data next to the table read
  typedef struct packed {
    logic [LVL_W-1:0]  v;
    logic              s_zero;
  } hsvg_s6_t;

endpackage

/* hw/rtl/hsvg_if.sv */
// Valid/ready channel interfaces for the input and result beats.
interface hsvg_in_if;
  import hsvg_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [HUE_W-1:0] hue;
  logic [LVL_W-1:0] saturation;
  logic [LVL_W-1:0] brightness;
  logic [LVL_W-1:0] table_index;
  logic [LVL_W-1:0] table_value;

  modport source (
    output valid, operation, hue, saturation, brightness, table_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, operation, hue, saturation, brightness, table_index, table_value,
    output ready
  );
endinterface

interface hsvg_out_if;
  import hsvg_pkg::*;

  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] red;
  logic [LVL_W-1:0] green;
  logic [LVL_W-1:0] blue;

  modport source (
    output valid, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue,
    output ready
  );
endinterface

/* hw/rtl/hsv_to_rgb_gamma_core.sv */
// HSV to gamma corrected RGB conversion, top level.
//
// Input channel in_i carries one beat per operation. A convert beat
// (operation 0) takes hue 0..359 (larger values clamp to 359), saturation
// and brightness, and yields one beat on out_o with red, green and blue.
// A write beat (operation 1) stores table_value at gamma entry table_index
// and yields no result; it takes effect for every convert beat behind it.
// Gamma entries must be written before converts read them.
// One beat is accepted every cycle unless out_o stalls the full pipeline;
// a beat passes six register stages (sector split, products,
// numerators, reciprocal divides, channel select, table read), with the
// three channel lookups served by three copies of the gamma RAM.
// Reset clears the stage valid bits only; table contents are left as is.
// When out_o is stalled every full stage holds its beat, empty stages
// still fill, and in_i.ready drops once the whole pipeline is full.
module hsv_to_rgb_gamma_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsvg_in_if.sink    in_i,
  hsvg_out_if.source out_o
);
  import hsvg_pkg::*;

  hsvg_s2_link_t s2;
  hsvg_s4_link_t s4;
  logic          s2_ready;
  logic          s4_ready;

  hsvg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .s2_o       (s2),
    .s2_ready_i (s2_ready)
  );

  hsvg_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s2_i       (s2),
    .s2_ready_o (s2_ready),
    .s4_o       (s4),
    .s4_ready_i (s4_ready)
  );

  hsvg_gamma u_gamma (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s4_i       (s4),
    .s4_ready_o (s4_ready),
    .out_o      (out_o)
  );

  // An empty output stage means the whole chain can move
  a_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready
  ) else $error("input not ready while output stage is empty");

  // Scaled levels never exceed brightness
  a_levels_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s4.valid && (s4.data.op == OP_CONVERT) && !s4.data.s_zero) |->
      ((s4.data.p <= s4.data.v) && (s4.data.q <= s4.data.v) && (s4.data.t <= s4.data.v))
  ) else $error("p, q or t above brightness");

  // A stalled beat between front and scale stages holds
  a_s2_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s2.valid && !s2_ready) |=> (s2.valid && $stable(s2.data))
  ) else $error("stage 2 beat changed while stalled");

endmodule

/* hw/rtl/hsvg_ram.sv */
// Generic single write port RAM with one registered read port.
module hsvg_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/hsvg_front.sv */
// Stages 1 and 2: hue clamp and sector split, then the narrow products.
module hsvg_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  hsvg_in_if.sink                in_i,
  output hsvg_pkg::hsvg_s2_link_t s2_o,
  input  logic                   s2_ready_i
);
  import hsvg_pkg::*;

  logic             s1_valid_q;
  hsvg_s1_t         s1_q, s1_d;
  logic             s2_valid_q;
  hsvg_s2_t         s2_q, s2_d;
  logic             s1_en, s2_en;
  logic [HUE_W-1:0] hue_c;
  logic [HUE_W-1:0] base;
  hsvg_sector_e     sector;
  logic [FC_W-1:0]  fc;

  // A stage loads when empty or when its content moves on
  assign s2_en      = !s2_valid_q || s2_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_i.ready = s1_en;

  // Stage 1: clamp hue, find sector and offset
  always_comb begin
    hue_c = (in_i.hue > HUE_MAX) ? HUE_MAX : in_i.hue;
    priority if (hue_c >= HUE_W'(5 * SECTOR_DEG)) begin
      sector = SEC_M_R;
      base   = HUE_W'(5 * SECTOR_DEG);
    end else if (hue_c >= HUE_W'(4 * SECTOR_DEG)) begin
      sector = SEC_B_M;
      base   = HUE_W'(4 * SECTOR_DEG);
    end else if (hue_c >= HUE_W'(3 * SECTOR_DEG)) begin
      sector = SEC_C_B;
      base   = HUE_W'(3 * SECTOR_DEG);
    end else if (hue_c >= HUE_W'(2 * SECTOR_DEG)) begin
      sector = SEC_G_C;
      base   = HUE_W'(2 * SECTOR_DEG);
    end else if (hue_c >= HUE_W'(SECTOR_DEG)) begin
      sector = SEC_Y_G;
      base   = HUE_W'(SECTOR_DEG);
    end else begin
      sector = SEC_R_Y;
      base   = '0;
    end
  end

  always_comb begin
    s1_d.op     = hsvg_op_e'(in_i.operation);
    s1_d.sector = sector;
    s1_d.f      = F_W'(hue_c - base);
    s1_d.s      = in_i.saturation;
    s1_d.v      = in_i.brightness;
    s1_d.s_zero = (in_i.saturation == '0);
    s1_d.idx    = in_i.table_index;
    s1_d.val    = in_i.table_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: S*f, S*(60-f) and V*(255-S)
  always_comb begin
    fc          = FC_W'(SECTOR_DEG) - FC_W'(s1_q.f);
    s2_d.op     = s1_q.op;
    s2_d.sector = s1_q.sector;
    s2_d.v      = s1_q.v;
    s2_d.s_zero = s1_q.s_zero;
    s2_d.sf     = PROD_W'(s1_q.s) * PROD_W'(s1_q.f);
    s2_d.sfc    = PROD_W'(s1_q.s) * PROD_W'(fc);
    s2_d.pn     = PN_W'(s1_q.v) * (PN_W'(FULL) - PN_W'(s1_q.s));
    s2_d.idx    = s1_q.idx;
    s2_d.val    = s1_q.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o.valid = s2_valid_q;
  assign s2_o.data  = s2_q;

endmodule

/* hw/rtl/hsvg_scale.sv */
// Stages 3 and 4: wide numerators, then division by constants via reciprocals.
module hsvg_scale (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hsvg_pkg::hsvg_s2_link_t s2_i,
  output logic                    s2_ready_o,
  output hsvg_pkg::hsvg_s4_link_t s4_o,
  input  logic                    s4_ready_i
);
  import hsvg_pkg::*;

  localparam int unsigned PPROD_W = PN_W + P_RECIP_W;
  localparam int unsigned QPROD_W = QT_W + QT_RECIP_W;

  logic               s3_valid_q;
  hsvg_s3_t           s3_q, s3_d;
  logic               s4_valid_q;
  hsvg_s4_t           s4_q, s4_d;
  logic               s3_en, s4_en;
  logic [PPROD_W-1:0] p_prod;
  logic [QPROD_W-1:0] q_prod;
  logic [QPROD_W-1:0] t_prod;

  assign s4_en      = !s4_valid_q || s4_ready_i;
  assign s3_en      = !s3_valid_q || s4_en;
  assign s2_ready_o = s3_en;

  // Stage 3: V*(15300 - S*f) and V*(15300 - S*(60-f))
  always_comb begin
    s3_d.op     = s2_i.data.op;
    s3_d.sector = s2_i.data.sector;
    s3_d.v      = s2_i.data.v;
    s3_d.s_zero = s2_i.data.s_zero;
    s3_d.qn     = QT_W'(s2_i.data.v) * QT_W'(PROD_W'(QT_DEN) - s2_i.data.sf);
    s3_d.tn     = QT_W'(s2_i.data.v) * QT_W'(PROD_W'(QT_DEN) - s2_i.data.sfc);
    s3_d.pn     = s2_i.data.pn;
    s3_d.idx    = s2_i.data.idx;
    s3_d.val    = s2_i.data.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_en) begin
      s3_valid_q <= s2_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_q <= s3_d;
    end
  end

  // Stage 4: floor divisions by 255 and 15300 as reciprocal multiplies
  always_comb begin
    p_prod      = PPROD_W'(s3_q.pn) * PPROD_W'(P_RECIP);
    q_prod      = QPROD_W'(s3_q.qn) * QPROD_W'(QT_RECIP);
    t_prod      = QPROD_W'(s3_q.tn) * QPROD_W'(QT_RECIP);
    s4_d.op     = s3_q.op;
    s4_d.sector = s3_q.sector;
    s4_d.v      = s3_q.v;
    s4_d.s_zero = s3_q.s_zero;
    s4_d.p      = p_prod[P_SHIFT +: LVL_W];
    s4_d.q      = q_prod[QT_SHIFT +: LVL_W];
    s4_d.t      = t_prod[QT_SHIFT +: LVL_W];
    s4_d.idx    = s3_q.idx;
    s4_d.val    = s3_q.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_en) begin
      s4_q <= s4_d;
    end
  end

  assign s4_o.valid = s4_valid_q;
  assign s4_o.data  = s4_q;

endmodule

/* hw/rtl/hsvg_gamma.sv */
// Stages 5 and 6: sector channel select, then gamma table lookup and output.
module hsvg_gamma (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hsvg_pkg::hsvg_s4_link_t s4_i,
  output logic                    s4_ready_o,
  hsvg_out_if.source              out_o
);
  import hsvg_pkg::*;

  logic             s5_valid_q;
  hsvg_s5_t         s5_q, s5_d;
  logic             s6_valid_q, s6_valid_d;
  hsvg_s6_t         s6_q, s6_d;
  logic             s5_en, s6_en;
  logic             tbl_we, tbl_re;
  logic [LVL_W-1:0] r_rdata, g_rdata, b_rdata;

  assign s6_en      = !s6_valid_q || out_o.ready;
  assign s5_en      = !s5_valid_q || s6_en;
  assign s4_ready_o = s5_en;

  // Stage 5: pick V, p, q or t per channel
  always_comb begin
    s5_d.op     = s4_i.data.op;
    s5_d.v      = s4_i.data.v;
    s5_d.s_zero = s4_i.data.s_zero;
    s5_d.idx    = s4_i.data.idx;
    s5_d.val    = s4_i.data.val;
    unique case (s4_i.data.sector)
      SEC_R_Y: begin
        s5_d.r = s4_i.data.v; s5_d.g = s4_i.data.t; s5_d.b = s4_i.data.p;
      end
      SEC_Y_G: begin
        s5_d.r = s4_i.data.q; s5_d.g = s4_i.data.v; s5_d.b = s4_i.data.p;
      end
      SEC_G_C: begin
        s5_d.r = s4_i.data.p; s5_d.g = s4_i.data.v; s5_d.b = s4_i.data.t;
      end
      SEC_C_B: begin
        s5_d.r = s4_i.data.p; s5_d.g = s4_i.data.q; s5_d.b = s4_i.data.v;
      end
      SEC_B_M: begin
        s5_d.r = s4_i.data.t; s5_d.g = s4_i.data.p; s5_d.b = s4_i.data.v;
      end
      SEC_M_R: begin
        s5_d.r = s4_i.data.v; s5_d.g = s4_i.data.p; s5_d.b = s4_i.data.q;
      end
      default: begin
        s5_d.r = s4_i.data.v; s5_d.g = s4_i.data.p; s5_d.b = s4_i.data.q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (s5_en) begin
      s5_valid_q <= s4_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_en) begin
      s5_q <= s5_d;
    end
  end

  // Stage 6: writes update all three table copies in beat order;
  // converts with nonzero saturation read them; all converts become result beats
  assign tbl_we     = s6_en && s5_valid_q && (s5_q.op == OP_WRITE);
  assign tbl_re     = s6_en && s5_valid_q && (s5_q.op == OP_CONVERT) && !s5_q.s_zero;
  assign s6_valid_d = s5_valid_q && (s5_q.op == OP_CONVERT);
  assign s6_d.v      = s5_q.v;
  assign s6_d.s_zero = s5_q.s_zero;

  hsvg_ram #(
    .WIDTH (LVL_W),
    .DEPTH (GAMMA_DEPTH)
  ) u_tbl_r (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s5_q.idx),
    .wdata_i (s5_q.val),
    .re_i    (tbl_re),
    .raddr_i (s5_q.r),
    .rdata_o (r_rdata)
  );

  hsvg_ram #(
    .WIDTH (LVL_W),
    .DEPTH (GAMMA_DEPTH)
  ) u_tbl_g (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s5_q.idx),
    .wdata_i (s5_q.val),
    .re_i    (tbl_re),
    .raddr_i (s5_q.g),
    .rdata_o (g_rdata)
  );

  hsvg_ram #(
    .WIDTH (LVL_W),
    .DEPTH (GAMMA_DEPTH)
  ) u_tbl_b (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s5_q.idx),
    .wdata_i (s5_q.val),
    .re_i    (tbl_re),
    .raddr_i (s5_q.b),
    .rdata_o (b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (s6_en) begin
      s6_valid_q <= s6_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s6_en) begin
      s6_q <= s6_d;
    end
  end

  // Gray pixels bypass the table
  assign out_o.valid = s6_valid_q;
  assign out_o.red   = s6_q.s_zero ? s6_q.v : r_rdata;
  assign out_o.green = s6_q.s_zero ? s6_q.v : g_rdata;
  assign out_o.blue  = s6_q.s_zero ? s6_q.v : b_rdata;

endmodule

/* bench/hsv_to_rgb_gamma_core_chk.sv */
`timescale 1ns / 1ps
// Scoreboard for the HSV to RGB gamma core: gamma table shadow, pixel predictor, beat compare.
module hsv_to_rgb_gamma_core_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsvg_in_if          in_mon,
  hsvg_out_if         out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import hsvg_pkg::*;

  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } rgb_t;

  // Shadow copy of the gamma RAM, updated on every accepted write beat
  logic [LVL_W-1:0] gamma_shadow [GAMMA_DEPTH];
  rgb_t             rgb_pending_q [$];
  int unsigned      fail_cnt    = 0;
  int unsigned      pending_cnt = 0;
  int unsigned      checked_cnt = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending_cnt;
  assign checked_o  = checked_cnt;

  initial begin
    for (int i = 0; i < GAMMA_DEPTH; i++) gamma_shadow[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_cnt < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic check_level(input string chan, input logic [LVL_W-1:0] want,
                             input logic [LVL_W-1:0] got);
    if (got !== want) report_mismatch($sformatf("%s want %0d got %0d", chan, want, got));
  endtask

  // Expected pixel for one convert beat, against the current table contents
  function automatic rgb_t convert_pixel(input logic [HUE_W-1:0] hue,
                                         input logic [LVL_W-1:0] sat,
                                         input logic [LVL_W-1:0] bri);
    int unsigned      h, f, s, v, p, q, t;
    hsvg_sector_e     sec;
    logic [LVL_W-1:0] r, g, b;
    rgb_t             res;
    // gray bypasses the table
    if (sat == '0) begin
      res.red   = bri;
      res.green = bri;
      res.blue  = bri;
      return res;
    end
    h   = (hue > HUE_MAX) ? int'(HUE_MAX) : int'(hue);
    s   = sat;
    v   = bri;
    sec = hsvg_sector_e'(3'(h / SECTOR_DEG));
    f   = h % SECTOR_DEG;
    p   = (v * (FULL - s)) / FULL;
    q   = (v * (QT_DEN - s * f)) / QT_DEN;
    t   = (v * (QT_DEN - s * (SECTOR_DEG - f))) / QT_DEN;
    case (sec)
      SEC_R_Y: begin r = LVL_W'(v); g = LVL_W'(t); b = LVL_W'(p); end
      SEC_Y_G: begin r = LVL_W'(q); g = LVL_W'(v); b = LVL_W'(p); end
      SEC_G_C: begin r = LVL_W'(p); g = LVL_W'(v); b = LVL_W'(t); end
      SEC_C_B: begin r = LVL_W'(p); g = LVL_W'(q); b = LVL_W'(v); end
      SEC_B_M: begin r = LVL_W'(t); g = LVL_W'(p); b = LVL_W'(v); end
      default: begin r = LVL_W'(v); g = LVL_W'(p); b = LVL_W'(q); end
    endcase
    res.red   = gamma_shadow[r];
    res.green = gamma_shadow[g];
    res.blue  = gamma_shadow[b];
    return res;
  endfunction

  // Retire result beats first, then log the input beat of this edge
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        if (rgb_pending_q.size() == 0) begin
          report_mismatch($sformatf("result beat r=%0d g=%0d b=%0d with no convert pending",
                                    out_mon.red, out_mon.green, out_mon.blue));
        end else begin
          want = rgb_pending_q.pop_front();
          checked_cnt++;
          check_level("red", want.red, out_mon.red);
          check_level("green", want.green, out_mon.green);
          check_level("blue", want.blue, out_mon.blue);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_WRITE) begin
          gamma_shadow[in_mon.table_index] = in_mon.table_value;
        end else begin
          rgb_pending_q.push_back(convert_pixel(in_mon.hue, in_mon.saturation,
                                                in_mon.brightness));
        end
      end
      pending_cnt = rgb_pending_q.size();
    end
  end

endmodule

/* bench/hsv_to_rgb_gamma_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top: clock, reset, beat stimulus, output back-pressure and verdict.
module hsv_to_rgb_gamma_core_tb;
  import hsvg_pkg::*;

  localparam int unsigned IDLE_LIMIT       = 3000;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned RANDOM_PER_PHASE = 75;
  localparam int unsigned DRAIN_CYCLES     = 24;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_cnt, pending_cnt, checked_cnt;
  int unsigned snd_idle_pct = 13;
  int unsigned rcv_idle_pct = 79;
  int unsigned hold_left    = 0;
  int unsigned idle_run     = 0;
  int unsigned n_convert    = 0;
  int unsigned n_write      = 0;

  hsvg_in_if  in_if ();
  hsvg_out_if out_if ();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hsv_to_rgb_gamma_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  hsv_to_rgb_gamma_core_chk i_chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt),
    .checked_o  (checked_cnt)
  );

  // Offer one beat, with optional gap in front, and wait for acceptance
  task automatic send_beat(input hsvg_op_e op, input logic [HUE_W-1:0] hue,
                           input logic [LVL_W-1:0] sat, input logic [LVL_W-1:0] bri,
                           input logic [LVL_W-1:0] idx, input logic [LVL_W-1:0] val);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.hue         <= hue;
    in_if.saturation  <= sat;
    in_if.brightness  <= bri;
    in_if.table_index <= idx;
    in_if.table_value <= val;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (op == OP_WRITE) n_write++;
    else n_convert++;
  endtask

  // Unused fields carry random junk
  task automatic convert(input logic [HUE_W-1:0] hue, input logic [LVL_W-1:0] sat,
                         input logic [LVL_W-1:0] bri);
    send_beat(OP_CONVERT, hue, sat, bri, 8'($urandom), 8'($urandom));
  endtask

  task automatic write_entry(input logic [LVL_W-1:0] idx, input logic [LVL_W-1:0] val);
    send_beat(OP_WRITE, 9'($urandom), 8'($urandom), 8'($urandom), idx, val);
  endtask

  // Levels lean toward the ends of the range
  function automatic logic [LVL_W-1:0] pick_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly legal hues, some above 359 to hit the clamp
  function automatic logic [HUE_W-1:0] pick_hue();
    if ($urandom_range(9) == 0) return 9'($urandom_range(511, 360));
    return 9'($urandom_range(359));
  endfunction

  task automatic send_random_item();
    if ($urandom_range(99) < 15) write_entry(8'($urandom), 8'($urandom));
    else convert(pick_hue(), pick_level(), pick_level());
  endtask

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("hsv_to_rgb_gamma_core_tb: errors");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Stimulus
  initial begin
    in_if.valid       <= 1'b0;
    in_if.operation   <= OP_CONVERT;
    in_if.hue         <= '0;
    in_if.saturation  <= '0;
    in_if.brightness  <= '0;
    in_if.table_index <= '0;
    in_if.table_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gray pixel needs no table, so it can go before the load
    convert(9'd100, 8'd0, 8'd200);

    // load every gamma entry
    for (int i = 0; i < GAMMA_DEPTH; i++) write_entry(8'(i), 8'($urandom));

    // directed: table ends, sector edges, clamp, zero saturation and brightness
    write_entry(8'd0, 8'hFF);
    write_entry(8'd255, 8'h00);
    for (int k = 0; k < 6; k++) begin
      convert(9'(60 * k), 8'd255, 8'd255);
      convert(9'(60 * k + 59), 8'd170, 8'd255);
    end
    convert(9'd360, 8'd200, 8'd180);
    convert(9'd511, 8'd255, 8'd255);
    convert(9'd200, 8'd0, 8'd0);
    convert(9'd0, 8'd0, 8'd255);
    convert(9'd45, 8'd255, 8'd0);
    convert(9'd30, 8'd1, 8'd255);
    convert(9'd30, 8'd128, 8'd1);

    // random: receiver-heavy idling, then sender-heavy, then none with a long hold
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin snd_idle_pct = 13; rcv_idle_pct = 79; end
        1:       begin snd_idle_pct = 79; rcv_idle_pct = 13; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  hold_left = HOLD_CYCLES; end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_item();
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d converts, %0d gamma writes, %0d pixels compared",
             n_convert, n_write, checked_cnt);
    $display("summary: three stall profiles, one %0d-cycle output hold, %0d mismatches",
             HOLD_CYCLES, fail_cnt);
    if (fail_cnt == 0) begin
      $display("hsv_to_rgb_gamma_core_tb: clean");
    end else begin
      $display("hsv_to_rgb_gamma_core_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/hsvg_pkg.sv
hw/rtl/hsvg_if.sv
hw/rtl/hsvg_ram.sv
hw/rtl/hsvg_front.sv
hw/rtl/hsvg_scale.sv
hw/rtl/hsvg_gamma.sv
hw/rtl/hsv_to_rgb_gamma_core.sv
bench/hsv_to_rgb_gamma_core_chk.sv
bench/hsv_to_rgb_gamma_core_tb.sv
